### hdl/bec_pkg.sv
// ---------------------------------------------------------------------------
// bec_pkg: shared types and constants
// Item layouts, register indexes, navigation codes and step helpers for the
// button event controller.
// ---------------------------------------------------------------------------
`default_nettype none

package bec_pkg;

  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_ADDR_W-1:0] REG_MAGIC   = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] REG_TIMEOUT = 1'b1;

  localparam logic [31:0] MAGIC_RESET   = 32'd0;
  localparam logic [15:0] TIMEOUT_RESET = 16'd750;
  localparam logic [6:0]  VOLUME_RESET  = 7'd80;

  localparam logic [6:0]        VOLUME_MAX  = 7'd100;
  localparam logic [6:0]        VOLUME_STEP = 7'd5;
  localparam logic signed [4:0] ZOOM_MIN    = -5'sd5;
  localparam logic signed [4:0] ZOOM_MAX    = 5'sd10;

  localparam int IN_TDATA_W  = 176;
  localparam int OUT_TDATA_W = 32;

  typedef enum logic [1:0] {
    NAV_NONE = 2'd0,
    NAV_PREV = 2'd1,
    NAV_NEXT = 2'd2,
    NAV_QUIT = 2'd3
  } nav_t;

  // first field sits in the highest bits
  typedef struct packed {
    logic        consume;
    logic [31:0] now_ms;
    logic [63:0] status_word;
    logic [11:0] pad_buttons;
    logic [31:0] beat_count;
    logic [31:0] beat_tag;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] seek_seconds;
    logic signed [4:0]  zoom_step;
    logic [6:0]         volume_level;
    logic               paused;
    logic [1:0]         nav_request;
  } out_item_t;

  typedef struct packed {
    logic                  wr_en;
    logic [CFG_ADDR_W-1:0] addr;
    logic [CFG_DATA_W-1:0] wdata;
  } cfg_wr_t;

  function automatic logic signed [15:0] seek_step(input logic [1:0] sel);
    logic signed [15:0] s;
    case (sel)
      2'd0:    s = 16'sd5;
      2'd1:    s = 16'sd10;
      2'd2:    s = 16'sd30;
      default: s = 16'sd60;
    endcase
    return s;
  endfunction

  function automatic logic signed [15:0] sat_add(input logic signed [15:0] acc,
                                                 input logic signed [15:0] d);
    logic signed [16:0] sum;
    logic signed [15:0] res;
    sum = 17'(acc) + 17'(d);
    if (sum > 17'sd32767) begin
      res = 16'sh7FFF;
    end else if (sum < -17'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = sum[15:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

### hdl/bec_core.sv
// ---------------------------------------------------------------------------
// bec_core: control state and per-sample update
// Holds the configuration and control registers and works out the result of
// one poll sample; the state moves on when step_en is high.
// ---------------------------------------------------------------------------
`default_nettype none

module bec_core (
  input  wire                  clk,
  input  wire                  rst_n,
  input  bec_pkg::cfg_wr_t     cfg,
  input  wire                  step_en,
  input  bec_pkg::in_item_t    item,
  output bec_pkg::out_item_t   result
);

  logic [31:0]        magic_r;
  logic [15:0]        timeout_r;
  logic [11:0]        prev_buttons_r, prev_buttons_nxt;
  logic [4:0]         prev_trig_r, prev_trig_nxt;
  logic [31:0]        seen_count_r, seen_count_nxt;
  logic [31:0]        seen_time_r, seen_time_nxt;
  logic               pause_r, pause_nxt;
  logic [6:0]         volume_r, volume_nxt;
  logic signed [4:0]  zoom_r, zoom_nxt;
  logic signed [15:0] seek_r, seek_nxt;
  logic [1:0]         nav_r, nav_nxt;

  logic               tag_ok;
  logic               cnt_new;
  logic [31:0]        elapsed;
  logic               alive;
  logic [11:0]        up;
  logic [4:0]         trig;
  logic [4:0]         tup;
  logic signed [15:0] step;
  logic [6:0]         vol_a;
  logic signed [4:0]  zoom_a;
  logic signed [15:0] seek_a;
  logic [1:0]         nav_a;

  assign tag_ok  = (item.beat_tag == magic_r);
  assign cnt_new = (item.beat_count != seen_count_r);
  assign elapsed = item.now_ms - seen_time_r;
  assign alive   = tag_ok && (cnt_new || (elapsed <= {16'd0, timeout_r}));
  assign up      = item.pad_buttons & ~prev_buttons_r;
  assign trig    = item.status_word[36:32];
  assign tup     = trig & ~prev_trig_r;
  assign step    = bec_pkg::seek_step(item.status_word[7:6]);

  always_comb begin
    // seek edges saturate one after another in bit order
    seek_a = seek_r;
    if (up[0])  seek_a = bec_pkg::sat_add(seek_a, step);
    if (up[1])  seek_a = bec_pkg::sat_add(seek_a, -step);
    if (tup[3]) seek_a = bec_pkg::sat_add(seek_a, -step);
    if (tup[4]) seek_a = bec_pkg::sat_add(seek_a, step);

    vol_a = volume_r;
    if (up[5]) vol_a = (vol_a < bec_pkg::VOLUME_STEP) ? 7'd0 : vol_a - bec_pkg::VOLUME_STEP;
    if (up[6]) begin
      vol_a = (vol_a > bec_pkg::VOLUME_MAX - bec_pkg::VOLUME_STEP) ?
              bec_pkg::VOLUME_MAX : vol_a + bec_pkg::VOLUME_STEP;
    end

    zoom_a = zoom_r;
    if (up[7]) zoom_a = (zoom_a <= bec_pkg::ZOOM_MIN) ? bec_pkg::ZOOM_MIN : zoom_a - 5'sd1;
    if (up[8]) zoom_a = (zoom_a >= bec_pkg::ZOOM_MAX) ? bec_pkg::ZOOM_MAX : zoom_a + 5'sd1;

    // last navigation write wins
    nav_a = nav_r;
    if (up[2])  nav_a = bec_pkg::NAV_NEXT;
    if (up[3])  nav_a = bec_pkg::NAV_PREV;
    if (up[10]) nav_a = bec_pkg::NAV_PREV;
    if (up[11]) nav_a = bec_pkg::NAV_NEXT;
    if (tup[1]) nav_a = bec_pkg::NAV_PREV;
    if (tup[2]) nav_a = bec_pkg::NAV_NEXT;

    result.nav_request  = alive ? nav_a : bec_pkg::NAV_QUIT;
    result.paused       = alive ? (pause_r ^ up[4] ^ tup[0]) : pause_r;
    result.volume_level = alive ? vol_a : volume_r;
    result.zoom_step    = alive ? zoom_a : zoom_r;
    result.seek_seconds = alive ? seek_a : seek_r;

    prev_buttons_nxt = alive ? item.pad_buttons : prev_buttons_r;
    prev_trig_nxt    = alive ? trig : prev_trig_r;
    seen_count_nxt   = (tag_ok && cnt_new) ? item.beat_count : seen_count_r;
    seen_time_nxt    = (tag_ok && cnt_new) ? item.now_ms : seen_time_r;
    pause_nxt        = result.paused;
    volume_nxt       = result.volume_level;
    zoom_nxt         = result.zoom_step;
    nav_nxt          = item.consume ? bec_pkg::NAV_NONE : result.nav_request;
    seek_nxt         = item.consume ? 16'sd0 : result.seek_seconds;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r   <= bec_pkg::MAGIC_RESET;
      timeout_r <= bec_pkg::TIMEOUT_RESET;
    end else if (cfg.wr_en) begin
      unique case (cfg.addr)
        bec_pkg::REG_MAGIC:   magic_r   <= cfg.wdata;
        bec_pkg::REG_TIMEOUT: timeout_r <= cfg.wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_buttons_r <= '0;
      prev_trig_r    <= '0;
      seen_count_r   <= '0;
      seen_time_r    <= '0;
      pause_r        <= 1'b0;
      volume_r       <= bec_pkg::VOLUME_RESET;
      zoom_r         <= '0;
      seek_r         <= '0;
      nav_r          <= bec_pkg::NAV_NONE;
    end else if (step_en) begin
      prev_buttons_r <= prev_buttons_nxt;
      prev_trig_r    <= prev_trig_nxt;
      seen_count_r   <= seen_count_nxt;
      seen_time_r    <= seen_time_nxt;
      pause_r        <= pause_nxt;
      volume_r       <= volume_nxt;
      zoom_r         <= zoom_nxt;
      seek_r         <= seek_nxt;
      nav_r          <= nav_nxt;
    end
  end

  a_volume_range: assert property (@(posedge clk) disable iff (!rst_n)
    volume_r <= bec_pkg::VOLUME_MAX)
    else $error("volume out of range");

  a_zoom_range: assert property (@(posedge clk) disable iff (!rst_n)
    (zoom_r >= bec_pkg::ZOOM_MIN) && (zoom_r <= bec_pkg::ZOOM_MAX))
    else $error("zoom out of range");

  a_consume_clears: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && item.consume |=> (nav_r == bec_pkg::NAV_NONE) && (seek_r == 16'sd0))
    else $error("consume did not clear nav and seek");

  // consume may still clear the seek accumulator on a lost heartbeat
  a_lost_beat_holds: assert property (@(posedge clk) disable iff (!rst_n)
    step_en && !tag_ok && !item.consume |=>
      $stable(prev_buttons_r) && $stable(volume_r) && $stable(seek_r))
    else $error("state moved on a lost heartbeat");

endmodule

`default_nettype wire

### hdl/button_event_controller_unit.sv
// an item goes from the input register to the result register, which drives out_tvalid
// throughput: one item per cycle unless stalled; the control state updates in the same
// cycle the result register loads, so back-to-back samples see fresh state
// a stalled output holds its result while one more item waits in the input register
// reset: synchronous on rst_n low; volume 80, timeout 750 ms; data unreset, all else zero
// ---------------------------------------------------------------------------
// button_event_controller_unit: poll sample to control result
// Input register, control update and result register with stream handshake.
// ---------------------------------------------------------------------------
`default_nettype none

module button_event_controller_unit (
  input  wire                                clk,
  input  wire                                rst_n,
  input  wire                                cfg_wr_en,
  input  wire [bec_pkg::CFG_ADDR_W-1:0]      cfg_addr,
  input  wire [bec_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  wire                                in_tvalid,
  output logic                               in_tready,
  // beat_tag, beat_count, pad_buttons, status_word, now_ms, consume, zero pad
  input  wire [bec_pkg::IN_TDATA_W-1:0]      in_tdata,
  output logic                               out_tvalid,
  input  wire                                out_tready,
  // nav_request, paused, volume_level, zoom_step, seek_seconds, zero pad
  output logic [bec_pkg::OUT_TDATA_W-1:0]    out_tdata
);

  localparam int IN_W  = $bits(bec_pkg::in_item_t);
  localparam int OUT_W = $bits(bec_pkg::out_item_t);

  logic                 in_valid_r;
  bec_pkg::in_item_t    in_item_r;
  logic                 out_valid_r;
  bec_pkg::out_item_t   out_item_r;
  bec_pkg::out_item_t   result;
  bec_pkg::cfg_wr_t     cfg;
  logic                 advance;

  assign cfg.wr_en = cfg_wr_en;
  assign cfg.addr  = cfg_addr;
  assign cfg.wdata = cfg_wdata;

  assign advance   = in_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !in_valid_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_tready) begin
      in_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      in_item_r <= bec_pkg::in_item_t'(in_tdata[IN_W-1:0]);
    end
  end

  bec_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .cfg     (cfg),
    .step_en (advance),
    .item    (in_item_r),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(bec_pkg::OUT_TDATA_W-OUT_W){1'b0}}, out_item_r};

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> in_tready)
    else $error("input stalled with empty output register");

  a_advance_fills: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("result register not loaded");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !advance)
    else $error("pending result overwritten");

endmodule

`default_nettype wire

### tb/sv/testbench.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// testbench: button event controller unit
// Streams poll samples into the controller and checks every result against
// a cycle-free model of the heartbeat check, edge detection and the pause,
// volume, zoom, seek and navigation state, with random stalls on both sides.
// ---------------------------------------------------------------------------

module testbench;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int SEEK_SECONDS [4] = '{5, 10, 30, 60};

  localparam logic [11:0] PAD_RIGHT    = 12'h001;
  localparam logic [11:0] PAD_LEFT     = 12'h002;
  localparam logic [11:0] PAD_DOWN     = 12'h004;
  localparam logic [11:0] PAD_UP       = 12'h008;
  localparam logic [11:0] PAD_PAUSE    = 12'h010;
  localparam logic [11:0] PAD_VOL_DN   = 12'h020;
  localparam logic [11:0] PAD_VOL_UP   = 12'h040;
  localparam logic [11:0] PAD_ZOOM_OUT = 12'h080;
  localparam logic [11:0] PAD_ZOOM_IN  = 12'h100;
  localparam logic [11:0] PAD_PREV     = 12'h400;
  localparam logic [11:0] PAD_NEXT     = 12'h800;

  localparam logic [4:0] TRIG_PAUSE     = 5'h01;
  localparam logic [4:0] TRIG_PREV      = 5'h02;
  localparam logic [4:0] TRIG_NEXT      = 5'h04;
  localparam logic [4:0] TRIG_SEEK_BACK = 5'h08;
  localparam logic [4:0] TRIG_SEEK_FWD  = 5'h10;

  logic                            clk = 1'b0;
  logic                            rst_n = 1'b0;
  logic                            cfg_wr_en = 1'b0;
  logic [bec_pkg::CFG_ADDR_W-1:0]  cfg_addr = bec_pkg::REG_MAGIC;
  logic [bec_pkg::CFG_DATA_W-1:0]  cfg_wdata = '0;
  logic                            in_tvalid = 1'b0;
  logic                            in_tready;
  // beat_tag, beat_count, pad_buttons, status_word, now_ms, consume, zero pad
  logic [bec_pkg::IN_TDATA_W-1:0]  in_tdata = '0;
  logic                            out_tvalid;
  logic                            out_tready = 1'b0;
  // nav_request, paused, volume_level, zoom_step, seek_seconds, zero pad
  logic [bec_pkg::OUT_TDATA_W-1:0] out_tdata;

  // controller state as the model tracks it
  logic [31:0]        magic_now = bec_pkg::MAGIC_RESET;
  logic [15:0]        timeout_now = bec_pkg::TIMEOUT_RESET;
  logic [11:0]        held_buttons = '0;
  logic [4:0]         held_triggers = '0;
  logic [31:0]        beat_seen = '0;
  logic [31:0]        beat_seen_at = '0;
  logic               paused_now = 1'b0;
  logic [6:0]         volume_now = bec_pkg::VOLUME_RESET;
  logic signed [4:0]  zoom_now = '0;
  logic signed [15:0] seek_now = '0;
  bec_pkg::nav_t      nav_now = bec_pkg::NAV_NONE;

  bec_pkg::out_item_t pending_reports[$];
  int        mismatches = 0;
  int        cycles = 0;
  bit        tx_steady = 1'b0;
  bit        rx_stalls = 1'b1;
  int        out_hold = 0;

  button_event_controller_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[button_event_controller_unit] ERROR");
      $finish;
    end
  end

  // mostly short, now and then long
  function automatic int stall_len();
    if ($urandom_range(0, 9) < 8) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  always @(posedge clk) begin
    if (out_hold != 0) begin
      out_hold <= out_hold - 1;
      out_tready <= 1'b0;
    end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
      out_hold <= stall_len();
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  function automatic logic signed [15:0] clamp_seek(input logic signed [15:0] acc,
                                                    input int d);
    int v;
    v = int'(acc) + d;
    if (v > 32767) v = 32767;
    else if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  function automatic bec_pkg::out_item_t apply_poll_sample(input bec_pkg::in_item_t s);
    bec_pkg::out_item_t r;
    logic [11:0] rise;
    logic [4:0]  trig_rise;
    logic [31:0] elapsed;
    int          stp;
    int          v;
    bit          lost;
    lost = 1'b0;
    elapsed = s.now_ms - beat_seen_at;
    if (s.beat_tag != magic_now) begin
      lost = 1'b1;
    end else if (s.beat_count != beat_seen) begin
      beat_seen = s.beat_count;
      beat_seen_at = s.now_ms;
    end else if (elapsed > {16'd0, timeout_now}) begin
      lost = 1'b1;
    end
    if (lost) begin
      nav_now = bec_pkg::NAV_QUIT;
    end else begin
      stp = SEEK_SECONDS[s.status_word[7:6]];
      rise = s.pad_buttons & ~held_buttons;
      held_buttons = s.pad_buttons;
      trig_rise = s.status_word[36:32] & ~held_triggers;
      held_triggers = s.status_word[36:32];
      // pad bits first, then status triggers; later nav writes win
      if (|(rise & PAD_RIGHT)) seek_now = clamp_seek(seek_now, stp);
      if (|(rise & PAD_LEFT)) seek_now = clamp_seek(seek_now, -stp);
      if (|(rise & PAD_DOWN)) nav_now = bec_pkg::NAV_NEXT;
      if (|(rise & PAD_UP)) nav_now = bec_pkg::NAV_PREV;
      if (|(rise & PAD_PAUSE)) paused_now = ~paused_now;
      if (|(rise & PAD_VOL_DN)) begin
        v = int'(volume_now) - 5;
        volume_now = (v < 0) ? 7'd0 : 7'(v);
      end
      if (|(rise & PAD_VOL_UP)) begin
        v = int'(volume_now) + 5;
        volume_now = (v > 100) ? 7'd100 : 7'(v);
      end
      if (|(rise & PAD_ZOOM_OUT)) begin
        v = int'(zoom_now) - 1;
        zoom_now = (v < -5) ? -5'sd5 : 5'(v);
      end
      if (|(rise & PAD_ZOOM_IN)) begin
        v = int'(zoom_now) + 1;
        zoom_now = (v > 10) ? 5'sd10 : 5'(v);
      end
      if (|(rise & PAD_PREV)) nav_now = bec_pkg::NAV_PREV;
      if (|(rise & PAD_NEXT)) nav_now = bec_pkg::NAV_NEXT;
      if (|(trig_rise & TRIG_PAUSE)) paused_now = ~paused_now;
      if (|(trig_rise & TRIG_PREV)) nav_now = bec_pkg::NAV_PREV;
      if (|(trig_rise & TRIG_NEXT)) nav_now = bec_pkg::NAV_NEXT;
      if (|(trig_rise & TRIG_SEEK_BACK)) seek_now = clamp_seek(seek_now, -stp);
      if (|(trig_rise & TRIG_SEEK_FWD)) seek_now = clamp_seek(seek_now, stp);
    end
    r = '0;
    r.nav_request = nav_now;
    r.paused = paused_now;
    r.volume_level = volume_now;
    r.zoom_step = zoom_now;
    r.seek_seconds = seek_now;
    // the report shows the state before consume clears it
    if (s.consume) begin
      nav_now = bec_pkg::NAV_NONE;
      seek_now = '0;
    end
    return r;
  endfunction

  task automatic note_mismatch(input string why, input bec_pkg::out_item_t want,
                               input logic [31:0] got_word);
    bec_pkg::out_item_t got;
    got = got_word[30:0];
    mismatches++;
    if (mismatches <= 10)
      $display("mismatch (%s) cycle %0d: want nav=%0d paused=%0d vol=%0d zoom=%0d seek=%0d,",
               why, cycles, want.nav_request, want.paused, want.volume_level,
               want.zoom_step, want.seek_seconds,
               " got nav=%0d paused=%0d vol=%0d zoom=%0d seek=%0d pad=%b",
               got.nav_request, got.paused, got.volume_level, got.zoom_step,
               got.seek_seconds, got_word[31]);
  endtask

  always @(posedge clk) begin
    bec_pkg::out_item_t got;
    bec_pkg::out_item_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = out_tdata[30:0];
      if (pending_reports.size() == 0) begin
        note_mismatch("unexpected item", '0, out_tdata);
      end else begin
        want = pending_reports.pop_front();
        if (out_tdata[31] !== 1'b0 ||
            got.nav_request !== want.nav_request ||
            got.paused !== want.paused ||
            got.volume_level !== want.volume_level ||
            got.zoom_step !== want.zoom_step ||
            got.seek_seconds !== want.seek_seconds)
          note_mismatch("field", want, out_tdata);
      end
    end
  end

  task automatic send_sample(input bec_pkg::in_item_t s);
    int gap;
    bec_pkg::out_item_t expect_item;
    in_tdata <= {3'b000, s};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    expect_item = apply_poll_sample(s);
    pending_reports = {pending_reports, expect_item};
    gap = (tx_steady || $urandom_range(0, 1) == 0) ? 0 : stall_len();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic wait_for_reports();
    in_tvalid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // only called with the block idle
  task automatic set_config(input logic [31:0] magic, input logic [31:0] timeout_word);
    cfg_wr_en <= 1'b1;
    cfg_addr <= bec_pkg::REG_MAGIC;
    cfg_wdata <= magic;
    @(posedge clk);
    cfg_addr <= bec_pkg::REG_TIMEOUT;
    cfg_wdata <= timeout_word;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    magic_now = magic;
    timeout_now = timeout_word[15:0];
  endtask

  function automatic bec_pkg::in_item_t poll(input logic [31:0] tag,
                                             input logic [31:0] count,
                                             input logic [31:0] now,
                                             input logic [11:0] pad,
                                             input logic [63:0] status,
                                             input logic consume);
    bec_pkg::in_item_t s;
    s.beat_tag = tag;
    s.beat_count = count;
    s.now_ms = now;
    s.pad_buttons = pad;
    s.status_word = status;
    s.consume = consume;
    return s;
  endfunction

  // healthy heartbeat: right tag, fresh count
  function automatic bec_pkg::in_item_t live_poll(input logic [11:0] pad,
                                                  input logic [63:0] status,
                                                  input logic consume);
    return poll(magic_now, beat_seen + 32'd1, beat_seen_at + $urandom_range(0, 50),
                pad, status, consume);
  endfunction

  function automatic bec_pkg::in_item_t random_poll();
    bec_pkg::in_item_t s;
    int       kind;
    logic [31:0] flip;
    kind = $urandom_range(0, 99);
    s = live_poll(($urandom_range(0, 4) == 0) ? 12'($urandom) : 12'($urandom & $urandom),
                  {$urandom, $urandom}, $urandom_range(0, 3) == 0);
    s.status_word[36:32] = 5'($urandom & $urandom);
    if (kind < 8) begin
      flip = $urandom;
      if (flip == 0) flip = 32'd1;
      s.beat_tag = magic_now ^ flip;
    end else if (kind < 16) begin
      // stalled count, just at or past the timeout
      s.beat_count = beat_seen;
      s.now_ms = beat_seen_at + timeout_now + (($urandom_range(0, 2) == 0) ? 0 :
                 $urandom_range(1, 1000));
    end else if (kind < 40) begin
      s.beat_count = beat_seen;
      s.now_ms = beat_seen_at + $urandom_range(0, timeout_now);
    end else if (kind < 55) begin
      s.beat_count = $urandom;
      s.now_ms = $urandom;
    end
    return s;
  endfunction

  task automatic test_heartbeat_and_edges();
    logic [63:0] st;
    // reset settings: tag 0, 750 ms
    send_sample(poll(32'd0, 32'd0, 32'd0, 12'h000, 64'd0, 1'b0));
    send_sample(poll(32'd0, 32'd0, 32'd750, 12'h000, 64'd0, 1'b0));
    send_sample(poll(32'd0, 32'd0, 32'd751, 12'h000, 64'd0, 1'b1));
    send_sample(poll(32'd1, 32'd1, 32'd752, 12'hFFF, '1, 1'b0));
    wait_for_reports();
    set_config(32'hFFFF_FFFF, {16'hFFFF, bec_pkg::TIMEOUT_RESET});
    send_sample(poll(magic_now, 32'd1, 32'd100, 12'hFFF, '1, 1'b0));
    send_sample(poll(magic_now, 32'd2, 32'd101, 12'h000, 64'd0, 1'b1));
    for (int i = 0; i < 12; i++) begin
      st = 64'(i % 4) << 6;
      send_sample(poll(magic_now, 32'(3 + i), 32'(102 + i), 12'(1 << i), st, i % 3 == 2));
    end
    for (int i = 0; i < 5; i++) begin
      st = (64'd1 << (32 + i)) | (64'(i % 4) << 6);
      send_sample(poll(magic_now, 32'(20 + i), 32'(200 + i), 12'h000, st, i == 4));
    end
    // stall measured across the wrap of the ms clock
    send_sample(poll(magic_now, 32'hFFFF_FFFF, 32'hFFFF_FF00, 12'h000, 64'd0, 1'b0));
    send_sample(poll(magic_now, 32'hFFFF_FFFF, 32'h0000_01EE, 12'h000, 64'd0, 1'b0));
    send_sample(poll(magic_now, 32'hFFFF_FFFF, 32'h0000_01EF, 12'h000, 64'd0, 1'b1));
    wait_for_reports();
  endtask

  task automatic test_volume_zoom_limits();
    set_config($urandom, 32'd0);
    for (int i = 0; i < 40; i++)
      send_sample(live_poll((i % 2) ? 12'h000 : (PAD_VOL_DN | PAD_ZOOM_OUT),
                            {$urandom, $urandom}, $urandom_range(0, 1)));
    for (int i = 0; i < 44; i++)
      send_sample(live_poll((i % 2) ? 12'h000 : (PAD_VOL_UP | PAD_ZOOM_IN),
                            {$urandom, $urandom}, $urandom_range(0, 1)));
    wait_for_reports();
  endtask

  task automatic test_seek_saturation();
    logic [11:0] pad;
    logic [63:0] st;
    set_config($urandom, {16'($urandom), 16'hFFFF});
    // one seek edge of 60 s per item, alternating pad and status trigger
    for (int dir = 0; dir < 2; dir++) begin
      for (int i = 0; i < 560; i++) begin
        pad = 12'($urandom) & ~(PAD_RIGHT | PAD_LEFT);
        st = {$urandom, $urandom};
        st[7:6] = 2'd3;
        st[36:35] = 2'b00;
        if (i % 2 == 0) pad |= dir ? PAD_LEFT : PAD_RIGHT;
        else st[36:32] |= dir ? TRIG_SEEK_BACK : TRIG_SEEK_FWD;
        send_sample(live_poll(pad, st, i == 559));
      end
    end
    wait_for_reports();
  endtask

  task automatic test_random_polls();
    logic [31:0] magics [4];
    logic [31:0] timeouts [4];
    magics = '{32'd0, 32'hFFFF_FFFF, $urandom, $urandom};
    timeouts = '{32'd0, 32'hFFFF_FFFF, {16'($urandom), 16'($urandom_range(1, 100))},
                 32'(bec_pkg::TIMEOUT_RESET)};
    for (int ph = 0; ph < 4; ph++) begin
      set_config(magics[ph], timeouts[ph]);
      tx_steady = (ph == 0);
      rx_stalls = (ph != 0);
      for (int i = 0; i < 140; i++) begin
        send_sample(random_poll());
        if ($urandom_range(0, 99) == 0) wait_for_reports();
      end
      wait_for_reports();
    end
    tx_steady = 1'b0;
    rx_stalls = 1'b1;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    test_heartbeat_and_edges();
    test_volume_zoom_limits();
    test_seek_saturation();
    test_random_polls();
    wait_for_reports();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && pending_reports.size() == 0) begin
      $display("[button_event_controller_unit] OK");
    end else begin
      $display("[button_event_controller_unit] ERROR");
    end
    $finish;
  end

endmodule
